// ----- rtl/n_queens_backtrack_counter_top_macros.svh -----
// Assertion macros for the queens search block.
// NQBC_ASSERT checks only outside reset; NQBC_ASSERT_NR also checks across reset.
`ifndef N_QUEENS_BACKTRACK_COUNTER_TOP_MACROS_SVH
`define N_QUEENS_BACKTRACK_COUNTER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NQBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NQBC_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NQBC_ASSERT(lbl, prop, msg)
`define NQBC_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ----- rtl/nqbc_pkg.sv -----
package nqbc_pkg;

  localparam int MAX_SIZE = 16;
  localparam int COL_W    = 4;
  localparam int ROW_W    = 5;
  localparam int COUNT_W  = 24;
  localparam int PLACE_W  = 64;
  localparam int SIZE_W   = 5;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

  typedef logic [MAX_SIZE-1:0] mask_t;

  // Occupancy seen by one row: columns and both diagonals, diagonals kept relative
  typedef struct packed {
    mask_t cols;
    mask_t ld;
    mask_t rd;
  } masks_t;

  // Per-cell strobes from the sequencer
  typedef struct packed {
    logic load;
    logic place;
  } cell_ctrl_t;

  // Columns below the board size
  function automatic mask_t size_mask(input logic [ROW_W-1:0] n);
    mask_t m;
    for (int i = 0; i < MAX_SIZE; i++) begin
      m[i] = (ROW_W'(i) < n);
    end
    return m;
  endfunction

  // Columns at or above the first column to try
  function automatic mask_t from_mask(input logic [ROW_W-1:0] c);
    mask_t m;
    for (int i = 0; i < MAX_SIZE; i++) begin
      m[i] = (ROW_W'(i) >= c);
    end
    return m;
  endfunction

endpackage

// ----- rtl/nqbc_if.sv -----
// Start channel
interface nqbc_in_if;
  logic valid;
  logic ready;
  logic start_req;
  modport source (output valid, output start_req, input ready);
  modport sink (input valid, input start_req, output ready);
endinterface

// Result channel
interface nqbc_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] solution_count;
  logic        any_found;
  logic [63:0] first_placement;
  modport source (output valid, output solution_count, output any_found,
                  output first_placement, input ready);
  modport sink (input valid, input solution_count, input any_found,
                input first_placement, output ready);
endinterface

// Board size write channel
interface nqbc_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] board_size;
  modport source (output valid, output board_size, input ready);
  modport sink (input valid, input board_size, output ready);
endinterface

// ----- rtl/n_queens_backtrack_counter_top.sv -----
// Channel  Direction  Payload
// in_ch    sink       start_req
// out_ch   source     solution_count, any_found, first_placement
// cfg_ch   sink       board_size (always ready)
//
// A search takes one placement or backtrack step at a time, with an extra step for each
// solution found, plus a start and a hand-over.
// The step rate is set by the row cell chain: one active cell decides per cycle.
// Reset sets board_size to 8; there is no clearing pass.
// in_ch is ready only between searches; a result waits in the output register
// while the next start is taken, and a finished search holds until that register frees.
`include "n_queens_backtrack_counter_top_macros.svh"

module n_queens_backtrack_counter_top
  import nqbc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  nqbc_in_if.sink  in_ch,
  nqbc_out_if.source out_ch,
  nqbc_cfg_if.sink cfg_ch
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FINISH} state_t;

  state_t               state_r;
  logic [SIZE_W-1:0]    board_size_r;
  logic [ROW_W-1:0]     n_r;
  mask_t                mask_r;
  logic [ROW_W-1:0]     row_r;
  logic [ROW_W-1:0]     next_r;
  logic [COUNT_W-1:0]   count_r;
  logic                 first_valid_r;
  logic [PLACE_W-1:0]   first_r;
  logic                 out_valid_r;
  logic [COUNT_W-1:0]   out_count_r;
  logic                 out_found_r;
  logic [PLACE_W-1:0]   out_place_r;

  masks_t               cell_in   [MAX_SIZE];
  masks_t               cell_out  [MAX_SIZE];
  cell_ctrl_t           cell_ctrl [MAX_SIZE];
  logic [COL_W-1:0]     cell_col  [MAX_SIZE];
  logic [MAX_SIZE-1:0]  found_v;
  logic [MAX_SIZE-1:0]  place_v;

  logic                 start_go;
  logic                 at_end;
  logic                 run_place;
  logic [COL_W-1:0]     row_idx;
  logic [COL_W-1:0]     prev_idx;
  logic [ROW_W-1:0]     size_sat;
  logic [PLACE_W-1:0]   packed_place;
  logic                 out_load;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.solution_count  = out_count_r;
  assign out_ch.any_found       = out_found_r;
  assign out_ch.first_placement = out_place_r;

  // Load the output register when a search is done and the register is free
  assign out_load = (state_r == S_FINISH) && (!out_valid_r || out_ch.ready);

  // Decode the current step
  always_comb begin
    start_go  = in_ch.valid && in_ch.ready && in_ch.start_req;
    size_sat  = (board_size_r > SIZE_W'(MAX_SIZE)) ? ROW_W'(MAX_SIZE) : board_size_r;
    row_idx   = row_r[COL_W-1:0];
    prev_idx  = row_idx - COL_W'(1);
    at_end    = (row_r == n_r);
    run_place = (state_r == S_RUN) && !at_end && found_v[row_idx];
    for (int i = 0; i < MAX_SIZE; i++) begin
      place_v[i] = run_place && (row_idx == COL_W'(i));
      packed_place[COL_W*i +: COL_W] = (ROW_W'(i) < n_r) ? cell_col[i] : '0;
    end
  end

  // Chain of row cells: each loads its occupancy when the row above places, the first on start
  for (genvar g = 0; g < MAX_SIZE; g++) begin : g_row
    if (g == 0) begin : g_first
      assign cell_in[g]        = '0;
      assign cell_ctrl[g].load = start_go;
    end else begin : g_rest
      assign cell_in[g]        = cell_out[g-1];
      assign cell_ctrl[g].load = place_v[g-1];
    end
    assign cell_ctrl[g].place = place_v[g];

    nqbc_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[g]),
      .masks_in   (cell_in[g]),
      .start_col  (next_r),
      .board_mask (mask_r),
      .masks_out  (cell_out[g]),
      .found      (found_v[g]),
      .col_r      (cell_col[g])
    );
  end

  // Sequence the search and hold the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      board_size_r  <= SIZE_RESET;
      out_valid_r   <= 1'b0;
      count_r       <= '0;
      first_valid_r <= 1'b0;
      row_r         <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        board_size_r <= cfg_ch.board_size;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (start_go) begin
            n_r           <= size_sat;
            mask_r        <= size_mask(size_sat);
            row_r         <= '0;
            next_r        <= '0;
            count_r       <= '0;
            first_valid_r <= 1'b0;
            first_r       <= '0;
            state_r       <= (size_sat == '0) ? S_FINISH : S_RUN;
          end
        end
        S_RUN: begin
          if (at_end) begin
            // count the solution, keep the first, step back
            count_r <= count_r + COUNT_W'(1);
            if (!first_valid_r) begin
              first_r       <= packed_place;
              first_valid_r <= 1'b1;
            end
            row_r  <= row_r - ROW_W'(1);
            next_r <= {1'b0, cell_col[prev_idx]} + ROW_W'(1);
          end else if (found_v[row_idx]) begin
            row_r  <= row_r + ROW_W'(1);
            next_r <= '0;
          end else if (row_r == '0) begin
            state_r <= S_FINISH;
          end else begin
            row_r  <= row_r - ROW_W'(1);
            next_r <= {1'b0, cell_col[prev_idx]} + ROW_W'(1);
          end
        end
        S_FINISH: begin
          if (out_load) begin
            out_count_r <= count_r;
            out_found_r <= first_valid_r;
            out_place_r <= first_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `NQBC_ASSERT(a_row_bound, (state_r == S_RUN) |-> (row_r <= n_r), "row beyond board size")
  `NQBC_ASSERT(a_one_place, $onehot0(place_v), "more than one row placing")
  `NQBC_ASSERT(a_found_count, first_valid_r == (count_r != '0), "found flag and count disagree")
  `NQBC_ASSERT(a_out_load, $rose(out_valid_r) |-> $past(state_r == S_FINISH), "result without finish")
  `NQBC_ASSERT_NR(a_reset_idle, !rst_n |=> (state_r == S_IDLE) && !out_valid_r, "not idle after reset")

endmodule

// ----- rtl/nqbc_cell.sv -----
module nqbc_cell
  import nqbc_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  masks_t           masks_in,
  input  logic [ROW_W-1:0] start_col,
  input  mask_t            board_mask,
  output masks_t           masks_out,
  output logic             found,
  output logic [COL_W-1:0] col_r
);

  masks_t           masks_r;
  mask_t            free;
  mask_t            queen;
  logic [COL_W-1:0] found_col;

  // Pick the lowest free column at or above the start column
  always_comb begin
    free      = ~(masks_r.cols | masks_r.ld | masks_r.rd) & board_mask & from_mask(start_col);
    found     = |free;
    found_col = '0;
    for (int i = MAX_SIZE - 1; i >= 0; i--) begin
      if (free[i]) begin
        found_col = COL_W'(i);
      end
    end
  end

  // Hand the occupancy with this queen added to the next row
  always_comb begin
    queen          = mask_t'(1) << found_col;
    masks_out.cols = masks_r.cols | queen;
    masks_out.ld   = (masks_r.ld | queen) << 1;
    masks_out.rd   = (masks_r.rd | queen) >> 1;
  end

  // Hold incoming occupancy and the chosen column
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      masks_r <= masks_in;
    end
    if (ctrl.place) begin
      col_r <= found_col;
    end
  end

endmodule
